// ===== hw/rtl/sbpd_pkg.sv =====
package sbpd_pkg;

	// frame buffering
	localparam int FRAME_BYTES = 16;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	// bytes that the decode can ever reach (version, flags, 9 field bytes)
	localparam int DEC_BYTES   = 11;
	localparam int IDX_W       = $clog2(DEC_BYTES);
	localparam int LEN_W       = $clog2(DEC_BYTES + 1);

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// flag byte bits
	localparam int FLAG_TEMP    = 7;
	localparam int FLAG_HUMID   = 6;
	localparam int FLAG_MAG_EN  = 5;
	localparam int FLAG_MAG_ST  = 4;
	localparam int FLAG_MOVE    = 3;
	localparam int FLAG_ANGLE   = 2;
	localparam int FLAG_BAT_LOW = 1;
	localparam int FLAG_BAT     = 0;

	localparam logic [12:0] BAT_BASE_MV = 13'd2000;

	// snapshot of one closed frame
	typedef struct packed {
		logic [DEC_BYTES*8-1:0] bytes;
		logic [LEN_W-1:0]       len;
	} snap_t;

	// one decoded result
	typedef struct packed {
		logic [7:0]         protocol_version;
		logic [4:0]         present_mask;
		logic signed [15:0] temperature_centi;
		logic [7:0]         humidity_percent;
		logic               magnet_detect_enabled;
		logic               magnet_state;
		logic               moving;
		logic [14:0]        movement_count;
		logic signed [7:0]  pitch_degrees;
		logic signed [15:0] roll_degrees;
		logic               battery_low;
		logic [12:0]        battery_mv;
	} result_t;

endpackage

// ===== hw/rtl/sbpd_in_if.sv =====
interface sbpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

// ===== hw/rtl/sbpd_out_if.sv =====
interface sbpd_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         protocol_version;
	logic [4:0]         present_mask;
	logic signed [15:0] temperature_centi;
	logic [7:0]         humidity_percent;
	logic               magnet_detect_enabled;
	logic               magnet_state;
	logic               moving;
	logic [14:0]        movement_count;
	logic signed [7:0]  pitch_degrees;
	logic signed [15:0] roll_degrees;
	logic               battery_low;
	logic [12:0]        battery_mv;

	modport source (output valid, output protocol_version, output present_mask,
		output temperature_centi, output humidity_percent, output magnet_detect_enabled,
		output magnet_state, output moving, output movement_count, output pitch_degrees,
		output roll_degrees, output battery_low, output battery_mv, input ready);
	modport sink (input valid, input protocol_version, input present_mask,
		input temperature_centi, input humidity_percent, input magnet_detect_enabled,
		input magnet_state, input moving, input movement_count, input pitch_degrees,
		input roll_degrees, input battery_low, input battery_mv, output ready);
endinterface

// ===== hw/rtl/sbpd_front.sv =====
module sbpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           data_byte,
	input  logic                 frame_last,
	output logic                 in_ready,
	output logic                 push,
	output sbpd_pkg::snap_t      push_data,
	input  logic                 q_ready
);

	logic [sbpd_pkg::CNT_W-1:0] count_q;
	logic [7:0]                 store_q [sbpd_pkg::DEC_BYTES];
	logic                       accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;

	// byte counter, saturates at the frame buffer size, clears on the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (frame_last) begin
				count_q <= '0;
			end else if (count_q < sbpd_pkg::CNT_W'(sbpd_pkg::FRAME_BYTES)) begin
				count_q <= count_q + sbpd_pkg::CNT_W'(1);
			end
		end
	end

	// keep only the bytes the decode can reach
	always_ff @(posedge clk) begin
		if (accept && count_q < sbpd_pkg::CNT_W'(sbpd_pkg::DEC_BYTES)) begin
			store_q[count_q[sbpd_pkg::IDX_W-1:0]] <= data_byte;
		end
	end

	// snapshot of the closed frame, the incoming byte merged at its slot
	always_comb begin
		for (int i = 0; i < sbpd_pkg::DEC_BYTES; i++) begin
			if (count_q == sbpd_pkg::CNT_W'(i)) begin
				push_data.bytes[i*8 +: 8] = data_byte;
			end else begin
				push_data.bytes[i*8 +: 8] = store_q[i];
			end
		end
		if (count_q >= sbpd_pkg::CNT_W'(sbpd_pkg::DEC_BYTES)) begin
			push_data.len = sbpd_pkg::LEN_W'(sbpd_pkg::DEC_BYTES);
		end else begin
			push_data.len = sbpd_pkg::LEN_W'(count_q) + sbpd_pkg::LEN_W'(1);
		end
	end

	// only frames of two bytes or more make a request
	assign push = accept && frame_last && (count_q != '0);

endmodule

// ===== hw/rtl/sbpd_queue.sv =====
module sbpd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbpd_pkg::snap_t push_data,
	output logic            q_ready,
	input  logic            pop,
	output logic            head_valid,
	output sbpd_pkg::snap_t head
);

	sbpd_pkg::snap_t             mem_q [sbpd_pkg::Q_DEPTH];
	logic [sbpd_pkg::QPTR_W-1:0] wr_q;
	logic [sbpd_pkg::QPTR_W-1:0] rd_q;
	logic [sbpd_pkg::QCNT_W-1:0] cnt_q;

	assign q_ready    = cnt_q < sbpd_pkg::QCNT_W'(sbpd_pkg::Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + sbpd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + sbpd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + sbpd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - sbpd_pkg::QCNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/sbpd_back.sv =====
module sbpd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  sbpd_pkg::snap_t   head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output sbpd_pkg::result_t result
);

	sbpd_pkg::result_t         dec;
	sbpd_pkg::result_t         result_q;
	logic                      valid_q;
	logic [7:0]                flags;
	logic [sbpd_pkg::LEN_W:0]  len_w;
	logic [sbpd_pkg::LEN_W:0]  off;
	logic [7:0]                bat;

	function automatic logic [7:0] byte_at(input logic [sbpd_pkg::DEC_BYTES*8-1:0] b,
		input logic [sbpd_pkg::LEN_W:0] pos);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < sbpd_pkg::DEC_BYTES; i++) begin
			if (pos == (sbpd_pkg::LEN_W + 1)'(i)) begin
				r = b[i*8 +: 8];
			end
		end
		return r;
	endfunction

	// field walk at the running offset
	always_comb begin
		dec   = '0;
		bat   = '0;
		flags = head.bytes[15:8];
		len_w = {1'b0, head.len};
		off   = (sbpd_pkg::LEN_W + 1)'(2);
		dec.protocol_version      = head.bytes[7:0];
		dec.magnet_detect_enabled = flags[sbpd_pkg::FLAG_MAG_EN];
		dec.magnet_state          = flags[sbpd_pkg::FLAG_MAG_ST];
		dec.battery_low           = flags[sbpd_pkg::FLAG_BAT_LOW];
		// temperature
		if (flags[sbpd_pkg::FLAG_TEMP] && len_w >= off + (sbpd_pkg::LEN_W + 1)'(2)) begin
			dec.temperature_centi = {byte_at(head.bytes, off),
				byte_at(head.bytes, off + (sbpd_pkg::LEN_W + 1)'(1))};
			dec.present_mask[0] = 1'b1;
			off = off + (sbpd_pkg::LEN_W + 1)'(2);
		end
		// humidity
		if (flags[sbpd_pkg::FLAG_HUMID] && len_w > off) begin
			dec.humidity_percent = byte_at(head.bytes, off);
			dec.present_mask[1]  = 1'b1;
			off = off + (sbpd_pkg::LEN_W + 1)'(1);
		end
		// movement word
		if (flags[sbpd_pkg::FLAG_MOVE] && len_w >= off + (sbpd_pkg::LEN_W + 1)'(2)) begin
			{dec.moving, dec.movement_count} = {byte_at(head.bytes, off),
				byte_at(head.bytes, off + (sbpd_pkg::LEN_W + 1)'(1))};
			dec.present_mask[2] = 1'b1;
			off = off + (sbpd_pkg::LEN_W + 1)'(2);
		end
		// pitch and roll
		if (flags[sbpd_pkg::FLAG_ANGLE] && len_w >= off + (sbpd_pkg::LEN_W + 1)'(3)) begin
			dec.pitch_degrees = byte_at(head.bytes, off);
			dec.roll_degrees  = {byte_at(head.bytes, off + (sbpd_pkg::LEN_W + 1)'(1)),
				byte_at(head.bytes, off + (sbpd_pkg::LEN_W + 1)'(2))};
			dec.present_mask[3] = 1'b1;
			off = off + (sbpd_pkg::LEN_W + 1)'(3);
		end
		// battery voltage, 2000 + 10 * byte
		if (flags[sbpd_pkg::FLAG_BAT] && len_w > off) begin
			bat = byte_at(head.bytes, off);
			dec.battery_mv = sbpd_pkg::BAT_BASE_MV + {2'b00, bat, 3'b000}
				+ {4'b0000, bat, 1'b0};
			dec.present_mask[4] = 1'b1;
		end
	end

	// output register, refilled while the sink takes the current result
	assign pop       = head_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= dec;
		end
	end

endmodule

// ===== hw/rtl/sensor_beacon_payload_decoder.sv =====
// channel   direction  request carries
// bytes     in         data_byte, frame_last
// results   out        one decoded frame per frame of two bytes or more
//
// one byte is taken each cycle while the frame queue has room; a frame's result
// passes the queue entry, then the output register; decode is running-offset logic
// arst_n clears the byte counter, the queue and the output valid
// bytes stall only when the two-entry frame queue is full, which needs the result
// side to hold back; bytes that are not last also wait then
module sensor_beacon_payload_decoder (
	input  logic        clk,
	input  logic        arst_n,
	sbpd_in_if.sink     bytes,
	sbpd_out_if.source  results
);

	logic              push;
	sbpd_pkg::snap_t   push_data;
	logic              q_ready;
	logic              pop;
	logic              head_valid;
	sbpd_pkg::snap_t   head;
	sbpd_pkg::result_t result;
	logic              in_ready;
	logic              out_valid;

	// frame capture
	sbpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (bytes.valid),
		.data_byte  (bytes.data_byte),
		.frame_last (bytes.frame_last),
		.in_ready   (in_ready),
		.push       (push),
		.push_data  (push_data),
		.q_ready    (q_ready)
	);

	// closed frames waiting for decode
	sbpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// decode and result register
	sbpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (results.ready),
		.result     (result)
	);

	assign bytes.ready                   = in_ready;
	assign results.valid                 = out_valid;
	assign results.protocol_version      = result.protocol_version;
	assign results.present_mask          = result.present_mask;
	assign results.temperature_centi     = result.temperature_centi;
	assign results.humidity_percent      = result.humidity_percent;
	assign results.magnet_detect_enabled = result.magnet_detect_enabled;
	assign results.magnet_state          = result.magnet_state;
	assign results.moving                = result.moving;
	assign results.movement_count        = result.movement_count;
	assign results.pitch_degrees         = result.pitch_degrees;
	assign results.roll_degrees          = result.roll_degrees;
	assign results.battery_low           = result.battery_low;
	assign results.battery_mv            = result.battery_mv;

endmodule

// ===== sim/sensor_beacon_payload_decoder_tb.sv =====
`timescale 1ns / 100ps

module sensor_beacon_payload_decoder_tb;

	localparam int RANDOM_BYTES = 1850;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int GAP_PERCENT  = 27;
	// window of cycles in which neither side holds back
	localparam int QUIET_FROM   = 800;
	localparam int QUIET_TO     = 1600;
	localparam int N_FIELDS     = 12;

	// present_mask bit positions
	localparam int PM_TEMP  = 0;
	localparam int PM_HUMID = 1;
	localparam int PM_MOVE  = 2;
	localparam int PM_ANGLE = 3;
	localparam int PM_BAT   = 4;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_TYPED_NONE
	} row_kind_t;

	typedef struct packed {
		logic [7:0]        data;
		logic              last;
		row_kind_t         kind;
		sbpd_pkg::result_t exp;
	} byte_row_t;

	localparam sbpd_pkg::result_t NONE_EXP = '0;
	// version, mask, temp, humidity, mag en, mag state, moving, count, pitch, roll, low, mv
	localparam sbpd_pkg::result_t EXP_ALL_HIGH = {8'hFF, 5'h1F, 16'h7FFF, 8'hFF,
		1'b1, 1'b1, 1'b1, 15'h7FFF, 8'h80, 16'h8000, 1'b1, 13'd4550};
	localparam sbpd_pkg::result_t EXP_ALL_LOW = {8'h00, 5'h1F, 16'h8000, 8'h00,
		1'b0, 1'b0, 1'b0, 15'h0000, 8'h7F, 16'h7FFF, 1'b0, 13'd2000};

	localparam int DIRECTED_LEN = 32;

	// directed frames
	byte_row_t directed_rows [DIRECTED_LEN] = '{
		// one-byte frame straight after reset closes without a result
		{8'h00, 1'b1, ROW_TYPED_NONE, NONE_EXP},
		// every field present, upper extremes
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h7F, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h80, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h80, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b1, ROW_TYPED, EXP_ALL_HIGH},
		// long frame with lower extremes, tail past the buffer is dropped
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hCD, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h80, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h7F, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h7F, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hA5, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h5A, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h00, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h3C, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hC3, 1'b1, ROW_TYPED, EXP_ALL_LOW},
		// all flags set but only humidity fits, the rest are skipped
		{8'h02, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'hFF, 1'b0, ROW_PREDICT, NONE_EXP},
		{8'h12, 1'b1, ROW_PREDICT, NONE_EXP}
	};

	string field_names [N_FIELDS] = '{"protocol_version", "present_mask",
		"temperature_centi", "humidity_percent", "magnet_detect_enabled", "magnet_state",
		"moving", "movement_count", "pitch_degrees", "roll_degrees", "battery_low",
		"battery_mv"};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	byte_row_t         byte_script [$];
	sbpd_pkg::result_t pending_decodes [$];
	int                drv_idx = 0;
	int                acc_idx = 0;
	int                err_cnt = 0;
	int                cyc = 0;

	// predictor copy of the frame buffer
	logic [7:0] frame_buf [sbpd_pkg::FRAME_BYTES];
	int         frame_cnt = 0;

	sbpd_in_if  byte_ch ();
	sbpd_out_if res_ch ();

	sensor_beacon_payload_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (res_ch)
	);

	always #5 clk = ~clk;

	// random hold-off, none inside the quiet window
	function automatic bit roll_gap();
		return (cyc < QUIET_FROM || cyc >= QUIET_TO) && ($urandom_range(99) < GAP_PERCENT);
	endfunction

	// buffer one byte; on a frame end of two bytes or more, decode it into r
	function automatic bit decode_byte(input logic [7:0] b, input logic lst,
			output sbpd_pkg::result_t r);
		int         len;
		int         off;
		logic [7:0] fl;
		r = '0;
		if (frame_cnt < sbpd_pkg::FRAME_BYTES) begin
			frame_buf[frame_cnt] = b;
			frame_cnt++;
		end
		if (!lst)
			return 1'b0;
		len = frame_cnt;
		frame_cnt = 0;
		if (len < 2)
			return 1'b0;
		fl = frame_buf[1];
		r.protocol_version = frame_buf[0];
		off = 2;
		if (fl[sbpd_pkg::FLAG_TEMP] && len >= off + 2) begin
			r.temperature_centi = {frame_buf[off], frame_buf[off + 1]};
			r.present_mask[PM_TEMP] = 1'b1;
			off += 2;
		end
		if (fl[sbpd_pkg::FLAG_HUMID] && len > off) begin
			r.humidity_percent = frame_buf[off];
			r.present_mask[PM_HUMID] = 1'b1;
			off += 1;
		end
		r.magnet_detect_enabled = fl[sbpd_pkg::FLAG_MAG_EN];
		r.magnet_state = fl[sbpd_pkg::FLAG_MAG_ST];
		if (fl[sbpd_pkg::FLAG_MOVE] && len >= off + 2) begin
			{r.moving, r.movement_count} = {frame_buf[off], frame_buf[off + 1]};
			r.present_mask[PM_MOVE] = 1'b1;
			off += 2;
		end
		if (fl[sbpd_pkg::FLAG_ANGLE] && len >= off + 3) begin
			r.pitch_degrees = frame_buf[off];
			r.roll_degrees = {frame_buf[off + 1], frame_buf[off + 2]};
			r.present_mask[PM_ANGLE] = 1'b1;
			off += 3;
		end
		r.battery_low = fl[sbpd_pkg::FLAG_BAT_LOW];
		if (fl[sbpd_pkg::FLAG_BAT] && len > off) begin
			r.battery_mv = sbpd_pkg::BAT_BASE_MV + 13'(10 * frame_buf[off]);
			r.present_mask[PM_BAT] = 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic logic [15:0] field_val(input sbpd_pkg::result_t r, input int k);
		case (k)
			0: return 16'(r.protocol_version);
			1: return 16'(r.present_mask);
			2: return r.temperature_centi;
			3: return 16'(r.humidity_percent);
			4: return 16'(r.magnet_detect_enabled);
			5: return 16'(r.magnet_state);
			6: return 16'(r.moving);
			7: return 16'(r.movement_count);
			8: return 16'(r.pitch_degrees);
			9: return r.roll_degrees;
			10: return 16'(r.battery_low);
			default: return 16'(r.battery_mv);
		endcase
	endfunction

	task automatic push_row(input logic [7:0] d, input logic l, input row_kind_t k,
			input sbpd_pkg::result_t e);
		byte_row_t row;
		row.data = d;
		row.last = l;
		row.kind = k;
		row.exp = e;
		byte_script.push_back(row);
	endtask

	// cycle count and timeout
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// byte request driver
	always @(posedge clk) begin
		if (arst_n && (!byte_ch.valid || byte_ch.ready)) begin
			if (drv_idx < byte_script.size() && !roll_gap()) begin
				byte_ch.valid <= 1'b1;
				byte_ch.data_byte <= byte_script[drv_idx].data;
				byte_ch.frame_last <= byte_script[drv_idx].last;
				drv_idx <= drv_idx + 1;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (arst_n)
			res_ch.ready <= !roll_gap();
	end

	// accepted bytes feed the predictor
	always @(posedge clk) begin
		sbpd_pkg::result_t dec;
		bit                got;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			got = decode_byte(byte_ch.data_byte, byte_ch.frame_last, dec);
			case (byte_script[acc_idx].kind)
				ROW_TYPED: begin
					pending_decodes.push_back(byte_script[acc_idx].exp);
				end
				ROW_PREDICT: begin
					if (got)
						pending_decodes.push_back(dec);
				end
				default: begin
				end
			endcase
			acc_idx++;
		end
	end

	// compare each accepted result with the oldest pending decode
	always @(posedge clk) begin
		sbpd_pkg::result_t act;
		sbpd_pkg::result_t exp;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			act.protocol_version = res_ch.protocol_version;
			act.present_mask = res_ch.present_mask;
			act.temperature_centi = res_ch.temperature_centi;
			act.humidity_percent = res_ch.humidity_percent;
			act.magnet_detect_enabled = res_ch.magnet_detect_enabled;
			act.magnet_state = res_ch.magnet_state;
			act.moving = res_ch.moving;
			act.movement_count = res_ch.movement_count;
			act.pitch_degrees = res_ch.pitch_degrees;
			act.roll_degrees = res_ch.roll_degrees;
			act.battery_low = res_ch.battery_low;
			act.battery_mv = res_ch.battery_mv;
			if (pending_decodes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, act);
				err_cnt++;
			end else begin
				exp = pending_decodes.pop_front();
				if (act !== exp) begin
					for (int k = 0; k < N_FIELDS; k++) begin
						if (field_val(act, k) !== field_val(exp, k))
							$display("%0t: %s expected %h actual %h", $time, field_names[k],
								field_val(exp, k), field_val(act, k));
					end
					err_cnt++;
				end
			end
		end
	end

	initial begin
		int pick;
		int flen;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.frame_last = 1'b0;
		res_ch.ready = 1'b0;

		// directed table first, then random frames of mostly well-formed length
		for (int i = 0; i < DIRECTED_LEN; i++)
			push_row(directed_rows[i].data, directed_rows[i].last, directed_rows[i].kind,
				directed_rows[i].exp);
		while (byte_script.size() < DIRECTED_LEN + RANDOM_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 8)
				flen = 1;
			else if (pick < 88)
				flen = $urandom_range(11, 2);
			else
				flen = $urandom_range(24, 12);
			for (int i = 0; i < flen; i++)
				push_row(8'($urandom_range(255)), i == flen - 1, ROW_PREDICT, NONE_EXP);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all bytes taken and all decodes returned
		while (acc_idx < byte_script.size() || pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sbpd_pkg.sv
hw/rtl/sbpd_in_if.sv
hw/rtl/sbpd_out_if.sv
hw/rtl/sbpd_front.sv
hw/rtl/sbpd_queue.sv
hw/rtl/sbpd_back.sv
hw/rtl/sensor_beacon_payload_decoder.sv
sim/sensor_beacon_payload_decoder_tb.sv
